// File: rtl/plgs_pkg.sv
package plgs_pkg;

    // Gray pixel width and the width of a product of two pixel-wide values.
    localparam int PIXEL_W = 8;
    localparam int PROD_W = 2 * PIXEL_W;

    // Configuration index width; indexes beyond the register list are ignored.
    localparam int CFG_INDEX_W = 8;

    // Default depth of the queue between the classifier and the divider pipeline.
    localparam int QUEUE_DEPTH = 4;

    // One divider stage per quotient bit.
    localparam int DIV_STAGES = PIXEL_W;

    localparam logic [PIXEL_W-1:0] PIXEL_MAX = {PIXEL_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_BREAK1_IN  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BREAK1_OUT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_BREAK2_IN  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_BREAK2_OUT = CFG_INDEX_W'(3);

    // One classified pixel: result = base +/- num / den.
    typedef struct packed {
        logic [PIXEL_W-1:0] base;
        logic               neg;
        logic [PROD_W-1:0]  num;
        logic [PIXEL_W-1:0] den;
    } job_t;

endpackage

// File: rtl/plgs_in_if.sv
interface plgs_in_if;
    logic                         valid;
    logic                         ready;
    logic [plgs_pkg::PIXEL_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

// File: rtl/plgs_out_if.sv
interface plgs_out_if;
    logic                         valid;
    logic                         ready;
    logic [plgs_pkg::PIXEL_W-1:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink (input valid, input pixel_out, output ready);
endinterface

// File: rtl/plgs_cfg_if.sv
interface plgs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [plgs_pkg::CFG_INDEX_W-1:0] index;
    logic [plgs_pkg::PIXEL_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/plgs_front.sv
module plgs_front (
    input  logic              clk,
    input  logic              rst_n,
    plgs_cfg_if.sink          cfg,
    plgs_in_if.sink           pixels,
    output logic              job_valid,
    input  logic              job_ready,
    output plgs_pkg::job_t    job
);

    logic [plgs_pkg::PIXEL_W-1:0] break1_in_reg;
    logic [plgs_pkg::PIXEL_W-1:0] break1_out_reg;
    logic [plgs_pkg::PIXEL_W-1:0] break2_in_reg;
    logic [plgs_pkg::PIXEL_W-1:0] break2_out_reg;

    logic                         valid_reg;
    plgs_pkg::job_t               job_reg;
    plgs_pkg::job_t               job_next;

    logic [plgs_pkg::PIXEL_W-1:0] p;
    logic [plgs_pkg::PIXEL_W-1:0] mul_a;
    logic [plgs_pkg::PIXEL_W-1:0] mul_b;
    logic                         accept;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break1_in_reg  <= '0;
            break1_out_reg <= '0;
            break2_in_reg  <= '0;
            break2_out_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                plgs_pkg::REG_BREAK1_IN:  break1_in_reg  <= cfg.data;
                plgs_pkg::REG_BREAK1_OUT: break1_out_reg <= cfg.data;
                plgs_pkg::REG_BREAK2_IN:  break2_in_reg  <= cfg.data;
                plgs_pkg::REG_BREAK2_OUT: break2_out_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Pick the segment, then set up one product and one divisor for it.
    always_comb
    begin
        p = pixels.pixel_in;
        job_next.neg = 1'b0;
        if (p <= break1_in_reg)
        begin
            job_next.base = '0;
            mul_a = break1_out_reg;
            mul_b = p;
            // A first breakpoint at zero only admits pixel zero, which maps to zero.
            job_next.den = (break1_in_reg == '0) ? plgs_pkg::PIXEL_W'(1) : break1_in_reg;
        end
        else if (p <= break2_in_reg)
        begin
            job_next.base = break1_out_reg;
            job_next.neg = (break2_out_reg < break1_out_reg);
            mul_a = job_next.neg ? (break1_out_reg - break2_out_reg)
                                 : (break2_out_reg - break1_out_reg);
            mul_b = p - break1_in_reg;
            job_next.den = break2_in_reg - break1_in_reg;
        end
        else
        begin
            // Here the pixel lies above the second breakpoint, so that breakpoint is below the top.
            job_next.base = break2_out_reg;
            mul_a = plgs_pkg::PIXEL_MAX - break2_out_reg;
            mul_b = p - break2_in_reg;
            job_next.den = plgs_pkg::PIXEL_MAX - break2_in_reg;
        end
        job_next.num = plgs_pkg::PROD_W'(mul_a) * plgs_pkg::PROD_W'(mul_b);
    end

    assign accept = pixels.valid && pixels.ready;
    assign pixels.ready = !valid_reg || job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (job_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job = job_reg;

`ifndef SYNTHESIS
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (job_reg.den != '0))
        else $error("classified pixel carries a zero divisor");
`endif

endmodule

// File: rtl/plgs_fifo.sv
module plgs_fifo #(
    parameter int DEPTH = plgs_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  plgs_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output plgs_pkg::job_t pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    plgs_pkg::job_t entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not drop on a lone pop");
`endif

endmodule

// File: rtl/plgs_back.sv
module plgs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  plgs_pkg::job_t job,
    plgs_out_if.source     stretched
);

    localparam int W = plgs_pkg::PIXEL_W;
    localparam int N = plgs_pkg::DIV_STAGES;

    logic         st_valid_reg [N];
    logic [W-1:0] st_rem_reg   [N];
    logic [W-1:0] st_low_reg   [N];
    logic [W-1:0] st_q_reg     [N];
    logic [W-1:0] st_den_reg   [N];
    logic [W-1:0] st_base_reg  [N];
    logic         st_neg_reg   [N];

    logic         in_valid [N];
    logic [W-1:0] in_rem   [N];
    logic [W-1:0] in_low   [N];
    logic [W-1:0] in_q     [N];
    logic [W-1:0] in_den   [N];
    logic [W-1:0] in_base  [N];
    logic         in_neg   [N];

    logic         out_valid_reg;
    logic [W-1:0] pixel_out_reg;
    logic [W-1:0] result;
    logic         adv;

    // The whole pipeline moves together whenever the output register can take a value.
    assign adv = !out_valid_reg || stretched.ready;
    assign job_ready = adv;

    // The quotient fits in W bits, so the upper half of the product is below the divisor.
    assign in_valid[0] = job_valid;
    assign in_rem[0]   = job.num[2*W-1:W];
    assign in_low[0]   = job.num[W-1:0];
    assign in_q[0]     = '0;
    assign in_den[0]   = job.den;
    assign in_base[0]  = job.base;
    assign in_neg[0]   = job.neg;

    genvar k;
    generate
        for (k = 1; k < N; k++)
        begin : g_link
            assign in_valid[k] = st_valid_reg[k-1];
            assign in_rem[k]   = st_rem_reg[k-1];
            assign in_low[k]   = st_low_reg[k-1];
            assign in_q[k]     = st_q_reg[k-1];
            assign in_den[k]   = st_den_reg[k-1];
            assign in_base[k]  = st_base_reg[k-1];
            assign in_neg[k]   = st_neg_reg[k-1];
        end

        for (k = 0; k < N; k++)
        begin : g_stage
            logic [W:0] trial;
            logic [W:0] diff;
            logic       ge;

            // One restoring step: bring down the next dividend bit and try a subtract.
            assign trial = {in_rem[k], in_low[k][W-1]};
            assign diff = trial - {1'b0, in_den[k]};
            assign ge = (trial >= {1'b0, in_den[k]});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    st_valid_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    st_valid_reg[k] <= in_valid[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    st_rem_reg[k]  <= ge ? diff[W-1:0] : trial[W-1:0];
                    st_low_reg[k]  <= {in_low[k][W-2:0], 1'b0};
                    st_q_reg[k]    <= {in_q[k][W-2:0], ge};
                    st_den_reg[k]  <= in_den[k];
                    st_base_reg[k] <= in_base[k];
                    st_neg_reg[k]  <= in_neg[k];
                end
            end
        end
    endgenerate

    assign result = st_neg_reg[N-1] ? (st_base_reg[N-1] - st_q_reg[N-1])
                                    : (st_base_reg[N-1] + st_q_reg[N-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= st_valid_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pixel_out_reg <= result;
        end
    end

    assign stretched.valid = out_valid_reg;
    assign stretched.pixel_out = pixel_out_reg;

`ifndef SYNTHESIS
    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> (job.num[2*W-1:W] < job.den))
        else $error("quotient would overflow the divider");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid_reg[N-1] && st_neg_reg[N-1]) |-> (st_q_reg[N-1] <= st_base_reg[N-1]))
        else $error("falling segment steps below zero");
`endif

endmodule

// File: rtl/piecewise_linear_gray_stretch.sv
// A pixel passes the front register, the queue, the divider stages and the output register.
// One pixel per cycle unless stalled; the divider pipeline computes one quotient bit per stage.
// Backpressure on the output stalls the divider pipeline; the queue keeps input open meanwhile.
// Reset (rst_n, asynchronous, active low) clears all breakpoints to zero and empties the queue.
module piecewise_linear_gray_stretch #(
    parameter int QUEUE_DEPTH = plgs_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    plgs_cfg_if.sink   cfg,
    plgs_in_if.sink    pixels,
    plgs_out_if.source stretched
);

    // Front to queue.
    logic           front_valid;
    logic           front_ready;
    plgs_pkg::job_t front_job;

    // Queue to divider pipeline.
    logic           back_valid;
    logic           back_ready;
    plgs_pkg::job_t back_job;

    // The front holds the breakpoint registers, finds the segment of each pixel, and forms
    // the product, the divisor and the base of that segment in one registered stage.
    plgs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pixels    (pixels),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    // A short queue parts the front from the divider, so a stall at the output does not
    // reach the input until the queue has filled.
    plgs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    // The back divides the product by the divisor one quotient bit per stage, then adds the
    // quotient to the base, or subtracts it on a falling segment, into the output register.
    plgs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .stretched (stretched)
    );

endmodule
